// ===== hdl/pfbw_pkg.sv =====
// Package for the panel frame buffer pixel writer.
// Holds panel geometry constants, command, draw mode and sequencer codes,
// and the draw mode bit update function. No dependencies.
`default_nettype none

package pfbw_pkg;

    localparam int MAX_PANELS_DEF = 8;
    localparam int PANEL_BYTES    = 64;

    localparam logic [7:0] BYTE_OFF  = 8'hFF;
    localparam logic [7:0] BYTE_LIT  = 8'h00;
    localparam logic [7:0] MASK_MSB  = 8'h80;
    localparam logic [2:0] BIT_SEL   = 3'h7;

    localparam logic [3:0] PANELS_RESET = 4'd1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_INVERSE = 3'd1,
        MODE_TOGGLE  = 3'd2,
        MODE_OR      = 3'd3,
        MODE_NOR     = 3'd4
    } t_mode;

    typedef enum logic [0:0] {
        CFG_PANELS_WIDE = 1'b0,
        CFG_PANELS_HIGH = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_TOTAL,
        ST_MUL_ROW,
        ST_MUL_PANEL,
        ST_INDEX,
        ST_READ,
        ST_MODIFY,
        ST_FILL,
        ST_DONE
    } t_state;

    function automatic logic [7:0] apply_mode(
        input logic [7:0] b,
        input logic [7:0] mask,
        input logic [2:0] mode,
        input logic       on
    );
        logic [7:0] r;
        r = b;
        case (mode)
            MODE_NORMAL:  r = on ? (b & ~mask) : (b | mask);
            MODE_INVERSE: r = on ? (b | mask) : (b & ~mask);
            MODE_TOGGLE:  r = on ? (b ^ mask) : b;
            MODE_OR:      r = on ? (b & ~mask) : b;
            MODE_NOR:     r = on ? (b | mask) : b;
            default:      r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pfbw_store.sv =====
// Frame store memory: one write port, one read port with registered data.
// Used by panel_framebuffer_pixel_writer_core; no package dependencies.
`default_nettype none

module pfbw_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/panel_framebuffer_pixel_writer_core.sv =====
// Panel frame buffer pixel writer: sequencer, shared multiplier, output register.
// Depends on pfbw_pkg and pfbw_store.
//
// Usage:
//   Command words enter on the s_axis channel, one result word per command
//   leaves on m_axis (command code 3 is dropped without a result).
//   One command is processed at a time; s_axis tready is high only while
//   the sequencer is idle, so a new command is taken at the earliest in the
//   cycle after the previous result is loaded. A finished result sits in the
//   output register and the next command is taken meanwhile; the sequencer
//   then waits in its done state until the output register frees up.
//   Pixel write: from accept to result, three passes through the
//   shared 8x4 multiplier for panel total, row offset and panel row, an
//   index add, a store read and a read-modify-write. A write clipped by the
//   display bounds goes straight to the done state.
//   Byte read: a read state and a modify state, as the store read port is registered.
//   Fill: all STORE_BYTES store bytes are written, one store byte per cycle.
//   Reset: after i_rst_n releases, a clearing pass writes 0xFF to all
//   STORE_BYTES (MAX_PANELS * 64) bytes, one per cycle; s_axis tready stays
//   low for those cycles. Configuration writes are taken at any time and
//   must only occur while the block is idle.
//   Stalls on m_axis hold the result word; nothing is dropped.
`default_nettype none

module panel_framebuffer_pixel_writer_core #(
    parameter int MAX_PANELS = pfbw_pkg::MAX_PANELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command, x, y, draw_mode, pixel_on, byte_address
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,
    // byte_value, byte_index, clipped
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_wdata
);

    localparam int STORE_BYTES = MAX_PANELS * pfbw_pkg::PANEL_BYTES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam logic [15:0] STORE_LIMIT = 16'(STORE_BYTES);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(STORE_BYTES - 1);

    pfbw_pkg::t_state r_state, n_state;

    logic [3:0]    r_pw, r_ph;
    logic [1:0]    r_cmd, n_cmd;
    logic [7:0]    r_x, n_x;
    logic [6:0]    r_y, n_y;
    logic [2:0]    r_mode, n_mode;
    logic          r_on, n_on;
    logic [7:0]    r_total, n_total;
    logic [11:0]   r_row, n_row;
    logic [7:0]    r_pan, n_pan;
    logic [15:0]   r_idx, n_idx;
    logic [7:0]    r_fill_val, n_fill_val;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [7:0]    r_res_value, n_res_value;
    logic [8:0]    r_res_index, n_res_index;
    logic          r_res_clip, n_res_clip;
    logic          r_out_valid, n_out_valid;
    logic [17:0]   r_out_data, n_out_data;

    logic [7:0]    w_mul_a;
    logic [3:0]    w_mul_b;
    logic [11:0]   w_prod;

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic [7:0]    w_rd_data;
    logic [7:0]    w_new_byte;
    logic [7:0]    w_mask;

    logic [1:0]    w_in_cmd;
    logic [7:0]    w_in_x;
    logic [6:0]    w_in_y;
    logic [2:0]    w_in_mode;
    logic          w_in_on;
    logic [8:0]    w_in_addr;
    logic          w_accept;
    logic          w_in_clip;

    assign w_in_cmd  = i_s_axis_tdata[1:0];
    assign w_in_x    = i_s_axis_tdata[9:2];
    assign w_in_y    = i_s_axis_tdata[16:10];
    assign w_in_mode = i_s_axis_tdata[19:17];
    assign w_in_on   = i_s_axis_tdata[20];
    assign w_in_addr = i_s_axis_tdata[29:21];

    assign o_s_axis_tready = (r_state == pfbw_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_clip       = ({1'b0, w_in_x[7:5]} >= r_pw) || ({1'b0, w_in_y[6:4]} >= r_ph);

    always_comb begin
        w_mul_a = {4'd0, r_pw};
        w_mul_b = r_ph;
        case (r_state)
            pfbw_pkg::ST_MUL_ROW: begin
                w_mul_a = r_total;
                w_mul_b = r_y[3:0];
            end
            pfbw_pkg::ST_MUL_PANEL: begin
                w_mul_a = {4'd0, r_pw};
                w_mul_b = {1'b0, r_y[6:4]};
            end
            default: begin
                w_mul_a = {4'd0, r_pw};
                w_mul_b = r_ph;
            end
        endcase
    end

    assign w_prod     = 12'(w_mul_a * w_mul_b);
    assign w_mask     = pfbw_pkg::MASK_MSB >> (r_x[2:0] & pfbw_pkg::BIT_SEL);
    assign w_new_byte = pfbw_pkg::apply_mode(w_rd_data, w_mask, r_mode, r_on);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_mode      = r_mode;
        n_on        = r_on;
        n_total     = r_total;
        n_row       = r_row;
        n_pan       = r_pan;
        n_idx       = r_idx;
        n_fill_val  = r_fill_val;
        n_sweep     = r_sweep;
        n_res_value = r_res_value;
        n_res_index = r_res_index;
        n_res_clip  = r_res_clip;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_idx[AW-1:0];
        w_mem_wdata = w_new_byte;

        case (r_state)
            pfbw_pkg::ST_CLEAR, pfbw_pkg::ST_FILL: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_sweep;
                w_mem_wdata = r_fill_val;
                n_sweep     = r_sweep + 1'b1;
                if (r_sweep == SWEEP_LAST) begin
                    n_sweep = '0;
                    n_state = (r_state == pfbw_pkg::ST_FILL) ? pfbw_pkg::ST_DONE
                                                             : pfbw_pkg::ST_IDLE;
                end
            end
            pfbw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd  = w_in_cmd;
                    n_x    = w_in_x;
                    n_y    = w_in_y;
                    n_mode = w_in_mode;
                    n_on   = w_in_on;
                    case (w_in_cmd)
                        pfbw_pkg::CMD_WRITE: begin
                            if (w_in_clip) begin
                                n_res_value = pfbw_pkg::BYTE_LIT;
                                n_res_index = '0;
                                n_res_clip  = 1'b1;
                                n_state     = pfbw_pkg::ST_DONE;
                            end else begin
                                n_state = pfbw_pkg::ST_MUL_TOTAL;
                            end
                        end
                        pfbw_pkg::CMD_FILL: begin
                            n_fill_val  = w_in_on ? pfbw_pkg::BYTE_LIT : pfbw_pkg::BYTE_OFF;
                            n_res_value = w_in_on ? pfbw_pkg::BYTE_LIT : pfbw_pkg::BYTE_OFF;
                            n_res_index = '0;
                            n_res_clip  = 1'b0;
                            n_sweep     = '0;
                            n_state     = pfbw_pkg::ST_FILL;
                        end
                        pfbw_pkg::CMD_READ: begin
                            n_idx = {7'd0, w_in_addr};
                            if ({7'd0, w_in_addr} >= STORE_LIMIT) begin
                                n_res_value = pfbw_pkg::BYTE_LIT;
                                n_res_index = w_in_addr;
                                n_res_clip  = 1'b1;
                                n_state     = pfbw_pkg::ST_DONE;
                            end else begin
                                n_state = pfbw_pkg::ST_READ;
                            end
                        end
                        default: begin
                            n_state = pfbw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pfbw_pkg::ST_MUL_TOTAL: begin
                n_total = w_prod[7:0];
                n_state = pfbw_pkg::ST_MUL_ROW;
            end
            pfbw_pkg::ST_MUL_ROW: begin
                n_row   = w_prod;
                n_state = pfbw_pkg::ST_MUL_PANEL;
            end
            pfbw_pkg::ST_MUL_PANEL: begin
                n_pan   = w_prod[7:0];
                n_state = pfbw_pkg::ST_INDEX;
            end
            pfbw_pkg::ST_INDEX: begin
                n_idx   = 16'(r_x[4:3])
                        + ((16'(r_x[7:5]) + 16'(r_pan)) << 2)
                        + (16'(r_row) << 2);
                n_state = pfbw_pkg::ST_READ;
            end
            pfbw_pkg::ST_READ: begin
                if (r_idx >= STORE_LIMIT) begin
                    n_res_value = pfbw_pkg::BYTE_LIT;
                    n_res_index = '0;
                    n_res_clip  = 1'b1;
                    n_state     = pfbw_pkg::ST_DONE;
                end else begin
                    n_state = pfbw_pkg::ST_MODIFY;
                end
            end
            pfbw_pkg::ST_MODIFY: begin
                n_res_index = r_idx[8:0];
                n_res_clip  = 1'b0;
                if (r_cmd == pfbw_pkg::CMD_WRITE) begin
                    w_mem_we    = 1'b1;
                    n_res_value = w_new_byte;
                end else begin
                    n_res_value = w_rd_data;
                end
                n_state = pfbw_pkg::ST_DONE;
            end
            pfbw_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_res_clip, r_res_index, r_res_value};
                    n_state     = pfbw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfbw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfbw_pkg::ST_CLEAR;
            r_sweep     <= '0;
            r_fill_val  <= pfbw_pkg::BYTE_OFF;
            r_out_valid <= 1'b0;
            r_pw        <= pfbw_pkg::PANELS_RESET;
            r_ph        <= pfbw_pkg::PANELS_RESET;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_fill_val  <= n_fill_val;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfbw_pkg::CFG_PANELS_WIDE: r_pw <= i_cfg_wdata;
                    pfbw_pkg::CFG_PANELS_HIGH: r_ph <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_x         <= n_x;
        r_y         <= n_y;
        r_mode      <= n_mode;
        r_on        <= n_on;
        r_total     <= n_total;
        r_row       <= n_row;
        r_pan       <= n_pan;
        r_idx       <= n_idx;
        r_res_value <= n_res_value;
        r_res_index <= n_res_index;
        r_res_clip  <= n_res_clip;
        r_out_data  <= n_out_data;
    end

    pfbw_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rd_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_data};

endmodule

`default_nettype wire

// ===== tb/tb_panel_framebuffer_pixel_writer_core.sv =====
// Testbench for panel_framebuffer_pixel_writer_core: random and directed pixel writes,
// fills and byte reads across several panel layouts, checked word by word against
// a bit-exact frame store predictor. Depends on pfbw_pkg and the RTL only.
`default_nettype none

module tb_panel_framebuffer_pixel_writer_core;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int STORE_BYTES  = pfbw_pkg::MAX_PANELS_DEF * pfbw_pkg::PANEL_BYTES;
    localparam int NUM_PHASES   = 8;
    localparam int RAND_PER_PH  = 205;
    localparam int SETTLE_CYC   = 20;
    localparam int LIMIT_CYC    = 1500000;
    localparam int IDLE_PCT     = 33;

    localparam logic [31:0] WIDE_LIST = {4'd1, 4'd3, 4'd4, 4'd8, 4'd2, 4'd1, 4'd8, 4'd1};
    localparam logic [31:0] HIGH_LIST = {4'd1, 4'd1, 4'd2, 4'd8, 4'd4, 4'd8, 4'd1, 4'd1};

    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef struct packed {
        logic [8:0]    addr;
        logic          on;
        logic [2:0]    mode;
        logic [6:0]    y;
        logic [7:0]    x;
        pfbw_pkg::t_cmd op;
    } t_pix_cmd;

    typedef struct packed {
        logic       clipped;
        logic [8:0] index;
        logic [7:0] value;
    } t_byte_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [3:0]  i_cfg_wdata;

    t_pix_cmd     cmd_pend_q[$];
    t_byte_result byte_expect_q[$];
    logic [7:0]   frame_model[STORE_BYTES];
    logic [3:0]   geom_wide;
    logic [3:0]   geom_high;
    int unsigned  last_touch;
    int unsigned  idle_pct;
    int unsigned  err_cnt;
    logic         s_fire;

    panel_framebuffer_pixel_writer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYC * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic predict_frame_op(input t_pix_cmd c, output t_byte_result r);
        int unsigned w, h, total, panel, col, idx, px, py;
        logic [7:0]  mask, b;
        logic        has_res;
        r       = '0;
        has_res = 1'b1;
        w       = 32'(geom_wide);
        h       = 32'(geom_high);
        px      = 32'(c.x);
        py      = 32'(c.y);
        total   = w * h;
        case (c.op)
            pfbw_pkg::CMD_WRITE: begin
                if (px >= 32 * w || py >= 16 * h) begin
                    r.clipped = 1'b1;
                end else begin
                    panel = px / 32 + w * (py / 16);
                    col   = px % 32 + 32 * panel;
                    idx   = col / 8 + (py % 16) * (4 * total);
                    if (idx >= STORE_BYTES) begin
                        r.clipped = 1'b1;
                    end else begin
                        mask = pfbw_pkg::MASK_MSB >> col[2:0];
                        b    = frame_model[idx];
                        case (c.mode)
                            pfbw_pkg::MODE_NORMAL:  b = c.on ? (b & ~mask) : (b | mask);
                            pfbw_pkg::MODE_INVERSE: b = c.on ? (b | mask) : (b & ~mask);
                            pfbw_pkg::MODE_TOGGLE:  if (c.on) b = b ^ mask;
                            pfbw_pkg::MODE_OR:      if (c.on) b = b & ~mask;
                            pfbw_pkg::MODE_NOR:
                                if (c.on && (b & mask) == 8'h00) b = b | mask;
                            default:                b = b;
                        endcase
                        frame_model[idx] = b;
                        last_touch       = idx;
                        r.value          = b;
                        r.index          = idx[8:0];
                    end
                end
            end
            pfbw_pkg::CMD_FILL: begin
                b = c.on ? pfbw_pkg::BYTE_LIT : pfbw_pkg::BYTE_OFF;
                for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = b;
                r.value = b;
            end
            pfbw_pkg::CMD_READ: begin
                if (32'(c.addr) >= STORE_BYTES) begin
                    r.clipped = 1'b1;
                end else begin
                    r.value = frame_model[c.addr];
                end
                r.index = c.addr;
            end
            default: has_res = 1'b0;
        endcase
        return has_res;
    endfunction

    function automatic t_pix_cmd mk_cmd(input pfbw_pkg::t_cmd op, input logic [7:0] x,
                                        input logic [6:0] y, input logic [2:0] mode,
                                        input logic on, input logic [8:0] addr);
        t_pix_cmd c;
        c.op   = op;
        c.x    = x;
        c.y    = y;
        c.mode = mode;
        c.on   = on;
        c.addr = addr;
        return c;
    endfunction

    function automatic t_pix_cmd rand_cmd();
        t_pix_cmd    c;
        int unsigned pick;
        c    = t_pix_cmd'(30'($urandom));
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) c.mode = 3'($urandom_range(7));
        else c.mode = 3'($urandom_range(4));
        if (pick < 55 || pick >= 94) begin
            c.op = pfbw_pkg::CMD_WRITE;
            c.x  = 8'($urandom_range(32 * 32'(geom_wide) - 1));
            c.y  = 7'($urandom_range(16 * 32'(geom_high) - 1));
        end else if (pick < 65) begin
            c.op = pfbw_pkg::CMD_WRITE;
        end else if (pick < 88) begin
            c.op = pfbw_pkg::CMD_READ;
            if ($urandom_range(1) == 0) c.addr = 9'(last_touch);
        end else if (pick < 91) begin
            c.op = pfbw_pkg::CMD_FILL;
        end else begin
            c.op = pfbw_pkg::CMD_NONE;
        end
        return c;
    endfunction

    task automatic set_geometry(input logic [3:0] w, input logic [3:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pfbw_pkg::CFG_PANELS_WIDE;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_index <= pfbw_pkg::CFG_PANELS_HIGH;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        geom_wide = w;
        geom_high = h;
    endtask

    task automatic wait_drained();
        while (cmd_pend_q.size() != 0 || i_s_axis_tvalid || byte_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender and receiver: change inputs on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= idle_pct);
            if (!i_s_axis_tvalid || s_fire) begin
                if (cmd_pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_s_axis_tdata  <= {2'b00, cmd_pend_q.pop_front()};
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check results first, then predict the word taken on the same edge.
    always @(posedge i_clk) begin : monitor
        t_pix_cmd     taken;
        t_byte_result want, got;
        s_fire <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_byte_result'(o_m_axis_tdata[17:0]);
                if (byte_expect_q.size() == 0) begin
                    $display("%0t unexpected result word %h", $time, got);
                    err_cnt++;
                end else begin
                    want = byte_expect_q.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t byte_value exp %h got %h", $time, want.value, got.value);
                        err_cnt++;
                    end
                    if (got.index !== want.index) begin
                        $display("%0t byte_index exp %h got %h", $time, want.index, got.index);
                        err_cnt++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $display("%0t clipped exp %b got %b", $time, want.clipped,
                                 got.clipped);
                        err_cnt++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                taken = t_pix_cmd'(i_s_axis_tdata[29:0]);
                if (predict_frame_op(taken, want)) byte_expect_q.push_back(want);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = pfbw_pkg::CFG_PANELS_WIDE;
        i_cfg_wdata     = pfbw_pkg::PANELS_RESET;
        s_fire          = 1'b0;
        geom_wide       = pfbw_pkg::PANELS_RESET;
        geom_high       = pfbw_pkg::PANELS_RESET;
        last_touch      = 0;
        idle_pct        = IDLE_PCT;
        err_cnt         = 0;
        for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = pfbw_pkg::BYTE_OFF;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_geometry(WIDE_LIST[ph * 4 +: 4], HIGH_LIST[ph * 4 +: 4]);
            idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            if (ph == 0) begin
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd31, 7'd15,
                                            pfbw_pkg::MODE_NORMAL, 1'b1, 9'h1FF));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd31, 7'd15,
                                            pfbw_pkg::MODE_INVERSE, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd31, 7'd15,
                                            pfbw_pkg::MODE_INVERSE, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd31, 7'd15,
                                            pfbw_pkg::MODE_NORMAL, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd1, 7'd0,
                                            pfbw_pkg::MODE_TOGGLE, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd1, 7'd0,
                                            pfbw_pkg::MODE_TOGGLE, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd2, 7'd0,
                                            pfbw_pkg::MODE_OR, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd3, 7'd0,
                                            pfbw_pkg::MODE_OR, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NOR, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NOR, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd1, 7'd0,
                                            pfbw_pkg::MODE_NOR, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd4, 7'd1,
                                            MODE_RSVD5, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd5, 7'd2,
                                            MODE_RSVD6, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd31, 7'd0,
                                            MODE_RSVD7, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd32, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'd0, 7'd16,
                                            pfbw_pkg::MODE_NORMAL, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_WRITE, 8'hFF, 7'h7F,
                                            MODE_RSVD7, 1'b1, 9'h1FF));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_READ, 8'hFF, 7'h7F,
                                            MODE_RSVD7, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_READ, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b0, 9'h1FF));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_READ, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b0, 9'd63));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_NONE, 8'hFF, 7'h7F,
                                            MODE_RSVD7, 1'b1, 9'h1FF));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_FILL, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b1, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_READ, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b0, 9'd10));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_FILL, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b0, 9'd0));
                cmd_pend_q.push_back(mk_cmd(pfbw_pkg::CMD_READ, 8'd0, 7'd0,
                                            pfbw_pkg::MODE_NORMAL, 1'b0, 9'h1FF));
                wait_drained();
            end
            for (int n = 0; n < RAND_PER_PH; n++) begin
                // hold the sender until every pending result is back
                if (n == RAND_PER_PH / 2) wait_drained();
                cmd_pend_q.push_back(rand_cmd());
            end
            wait_drained();
            repeat (SETTLE_CYC) @(posedge i_clk);
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
